FILE: hdl/mrti_pkg.sv
`default_nettype none

package mrti_pkg;

	// digit store depth; token length limit in significant digits
	localparam int MAX_DIGITS = 64;
	localparam int IDX_W      = $clog2(MAX_DIGITS);
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
	localparam int DIGIT_W    = 6;
	localparam int VALUE_W    = 64;
	// product of a 64-bit magnitude and a 6-bit radix
	localparam int ACC_W      = VALUE_W + DIGIT_W;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CASE_OFS = 8'd32;
	localparam logic [7:0] ALPHA_BASE = 8'd10;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_BAD_SYMBOL = 2'd1;
	localparam logic [1:0] STATUS_TOO_BIG    = 2'd2;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_input;
	} in_word_t;

	typedef struct packed {
		logic [1:0]                status;
		logic [5:0]                radix;
		logic signed [VALUE_W-1:0] value;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT,
		ST_EMIT_ERR,
		ST_HALT
	} state_t;

	typedef struct packed {
		logic       gather;
		logic       conv_start;
		logic       conv_step;
		logic       set_err;
		logic [1:0] err_code;
		logic       set_ok;
		logic       load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic bad_char;
		logic finish;
		logic tok_lone;
		logic tok_long;
		logic conv_last;
		logic conv_ovf;
		logic out_free;
	} dp_stat_t;

	// {alnum, digit value}; upper case folds to lower
	function automatic logic [DIGIT_W:0] digit_of(input logic [7:0] c);
		logic [7:0] lc;
		logic [7:0] t;
		lc = (c >= CH_UA && c <= CH_UZ) ? c + CASE_OFS : c;
		t  = '0;
		if (c >= CH_0 && c <= CH_9) begin
			t = c - CH_0;
			return {1'b1, t[DIGIT_W-1:0]};
		end
		if (lc >= CH_LA && lc <= CH_LZ) begin
			t = lc - CH_LA + ALPHA_BASE;
			return {1'b1, t[DIGIT_W-1:0]};
		end
		return '0;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/mrti_ram.sv
`default_nettype none

module mrti_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/mrti_ctrl.sv
`default_nettype none

module mrti_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire mrti_pkg::dp_stat_t stat,
	output mrti_pkg::dp_cmd_t       cmd
);

	import mrti_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (stat.bad_char) begin
						cmd.set_err  = 1'b1;
						cmd.err_code = STATUS_BAD_SYMBOL;
						state_d      = ST_EMIT_ERR;
					end else if (stat.finish) begin
						if (stat.tok_lone) begin
							cmd.set_err  = 1'b1;
							cmd.err_code = STATUS_BAD_SYMBOL;
							state_d      = ST_EMIT_ERR;
						end else if (stat.tok_long) begin
							cmd.set_err  = 1'b1;
							cmd.err_code = STATUS_TOO_BIG;
							state_d      = ST_EMIT_ERR;
						end else begin
							cmd.conv_start = 1'b1;
							state_d        = ST_CONV;
						end
					end else begin
						cmd.gather = 1'b1;
					end
				end
			end
			ST_CONV: begin
				if (stat.conv_ovf) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = STATUS_TOO_BIG;
					state_d      = ST_EMIT_ERR;
				end else if (stat.conv_last) begin
					cmd.set_ok = 1'b1;
					state_d    = ST_EMIT;
				end else begin
					cmd.conv_step = 1'b1;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_EMIT_ERR: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_HALT;
				end
			end
			ST_HALT: begin
				// swallow everything until reset
				in_ready = 1'b1;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/mrti_dpath.sv
`default_nettype none

module mrti_dpath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mrti_pkg::in_word_t  in_word,
	input  wire mrti_pkg::dp_cmd_t   cmd,
	output mrti_pkg::dp_stat_t       stat,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output mrti_pkg::out_word_t      out_word
);

	import mrti_pkg::*;

	// token state
	logic [CNT_W-1:0]   count_q;
	logic [DIGIT_W-1:0] largest_q;
	logic               in_token_q;
	logic               neg_q;
	logic               pend_q;
	logic               over_q;
	logic               first_zero_q;

	// conversion
	logic [VALUE_W-1:0] mag_q;
	logic [IDX_W-1:0]   idx_q;
	out_word_t          res_q;
	out_word_t          out_q;
	logic               out_valid_q;

	logic [DIGIT_W:0]   dig;
	logic [DIGIT_W-1:0] d;
	logic               is_sep;
	logic               is_minus;
	logic               tok_char;
	logic               add_dig;
	logic               repl;
	logic               full;
	logic               clear;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	logic [DIGIT_W-1:0] ram_rdata;
	logic [DIGIT_W-1:0] radix_w;
	logic [ACC_W-1:0]   acc;
	logic [ACC_W-1:0]   limit;
	logic [VALUE_W-1:0] acc_lo;

	assign dig      = digit_of(in_word.ch);
	assign d        = dig[DIGIT_W-1:0];
	assign is_sep   = in_word.ch == CH_SPACE || in_word.ch == CH_TAB || in_word.ch == CH_NL;
	assign is_minus = in_word.ch == CH_MINUS;
	assign tok_char = !in_word.end_of_input && !is_sep;

	// a leading minus opens the token without adding a digit
	assign add_dig  = cmd.gather && tok_char && !(!in_token_q && is_minus);
	// a lone leading zero gets overwritten by the next digit
	assign repl     = count_q == CNT_W'(1) && first_zero_q;
	assign full     = count_q >= CNT_W'(MAX_DIGITS);
	assign clear    = cmd.set_err || cmd.set_ok;

	assign ram_we    = add_dig && (repl || !full);
	assign ram_waddr = repl ? '0 : count_q[IDX_W-1:0];
	assign ram_re    = cmd.conv_start || cmd.conv_step;
	assign ram_raddr = cmd.conv_start ? '0 : idx_q + IDX_W'(1);

	mrti_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (MAX_DIGITS)
	) u_digits (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (d),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign radix_w = largest_q + DIGIT_W'(1);
	assign acc     = ACC_W'(mag_q) * ACC_W'(radix_w) + ACC_W'(ram_rdata);
	assign limit   = neg_q ? ACC_W'({1'b1, {(VALUE_W-1){1'b0}}})
	                       : ACC_W'({1'b0, {(VALUE_W-1){1'b1}}});
	assign acc_lo  = acc[VALUE_W-1:0];

	always_comb begin
		stat.bad_char  = tok_char && !dig[DIGIT_W] && !(!in_token_q && is_minus);
		stat.finish    = !tok_char && in_token_q;
		stat.tok_lone  = pend_q || count_q == '0;
		stat.tok_long  = over_q;
		stat.conv_last = CNT_W'(idx_q) == count_q - CNT_W'(1);
		stat.conv_ovf  = acc > limit;
		stat.out_free  = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			largest_q    <= '0;
			in_token_q   <= 1'b0;
			neg_q        <= 1'b0;
			pend_q       <= 1'b0;
			over_q       <= 1'b0;
			first_zero_q <= 1'b0;
		end else if (clear) begin
			count_q      <= '0;
			largest_q    <= '0;
			in_token_q   <= 1'b0;
			neg_q        <= 1'b0;
			pend_q       <= 1'b0;
			over_q       <= 1'b0;
			first_zero_q <= 1'b0;
		end else begin
			if (cmd.gather && tok_char) begin
				in_token_q <= 1'b1;
			end
			if (cmd.gather && tok_char && !in_token_q && is_minus) begin
				neg_q  <= 1'b1;
				pend_q <= 1'b1;
			end
			if (add_dig) begin
				pend_q <= 1'b0;
				if (repl) begin
					largest_q    <= d;
					first_zero_q <= d == '0;
				end else if (full) begin
					over_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
					if (d > largest_q) begin
						largest_q <= d;
					end
					if (count_q == '0) begin
						first_zero_q <= d == '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.conv_start) begin
			mag_q <= '0;
			idx_q <= '0;
		end else if (cmd.conv_step) begin
			mag_q <= acc_lo;
			idx_q <= idx_q + IDX_W'(1);
		end
		if (cmd.set_err) begin
			res_q.status <= cmd.err_code;
			res_q.radix  <= '0;
			res_q.value  <= '0;
		end else if (cmd.set_ok) begin
			res_q.status <= STATUS_OK;
			res_q.radix  <= radix_w;
			res_q.value  <= neg_q ? -acc_lo : acc_lo;
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

`default_nettype wire

FILE: hdl/min_radix_token_to_integer_core.sv
// Token characters: one word per cycle.
// Token end: once the separator is accepted, the n significant digits are read back from
// the digit RAM, one per cycle, into the result register, then the output register.
// Input is not taken while a token is converted or its result waits to load.
// Async reset clears all control state; an error result halts the block until reset.
`default_nettype none

module min_radix_token_to_integer_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire mrti_pkg::in_word_t  in_word,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output mrti_pkg::out_word_t      out_word
);

	import mrti_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	mrti_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mrti_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_word),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

`default_nettype wire

FILE: hdl/mrti_checker.sv
`default_nettype none

module mrti_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire mrti_pkg::out_word_t out_word
);

	import mrti_pkg::*;

	logic seen_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_err_q <= 1'b0;
		end else if (out_valid && out_ready && out_word.status != STATUS_OK) begin
			seen_err_q <= 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word changed or dropped while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status != STATUS_OK |-> out_word.radix == '0 && out_word.value == '0)
		else $error("error word carries nonzero radix or value");

	a_ok_radix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status == STATUS_OK |-> out_word.radix != '0 && out_word.radix <= 6'd36)
		else $error("ok word with radix out of range");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.status == STATUS_OK || out_word.status == STATUS_BAD_SYMBOL
			|| out_word.status == STATUS_TOO_BIG)
		else $error("undefined status code");

	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		seen_err_q |-> !out_valid)
		else $error("result after error word");

endmodule

bind min_radix_token_to_integer_core mrti_checker u_mrti_checker (.*);

`default_nettype wire
